// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rse_pkg.sv -----
package rse_pkg;

    typedef logic [7:0] gf_t;

    localparam gf_t         GF_POLY_LOW      = 8'h1D;
    localparam int          PC_W             = 6;
    localparam int          CNT_W            = 9;
    localparam int          SUM_W            = 10;
    localparam logic [CNT_W-1:0] CNT_MAX     = 9'd511;
    localparam logic [SUM_W-1:0] FIELD_SIZE  = 10'd256;
    localparam logic [PC_W-1:0]  PC_RESET    = 6'd16;
    localparam logic [0:0]  REG_PARITY_COUNT = 1'b0;

    function automatic gf_t gf_xtime(gf_t a);
        gf_t s;
        s = {a[6:0], 1'b0};
        if (a[7])
        begin
            s = s ^ GF_POLY_LOW;
        end
        return s;
    endfunction

    function automatic gf_t gf_mul(gf_t a, gf_t b);
        gf_t x;
        gf_t r;
        x = a;
        r = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                r = r ^ x;
            end
            x = gf_xtime(x);
        end
        return r;
    endfunction

endpackage

// ----- rtl/rs_systematic_encoder.sv -----
// Systematic Reed-Solomon encoder, GF(2^8), field polynomial 0x11D.
// Config: APB register 0 (address 0) is parity_count; 0 acts as 1 and values
// above MAX_PARITY act as MAX_PARITY. A write rebuilds the generator and drops
// any message in progress. pready is always high.
// Input channel (in_valid/in_ready): one data byte per item, last_data on the
// final byte. Non-last bytes give no result. One item per cycle when in_ready.
// Output channel (out_valid/out_ready): after the last byte, n parity bytes,
// highest order first, last_parity on the final one. The first parity byte is
// valid the cycle after the last byte is taken; one per cycle with out_ready.
// If length plus n reaches 256, one item with length_error set is sent instead.
// Generator build: after reset and after each parity_count write,
// with in_ready low; it runs one polynomial factor per cycle.
// Output stall: parity bytes wait in an output shift register; data bytes of
// the next message are still taken, but its last byte waits until the
// previous parity burst has been fully taken.
`include "assert_macros.svh"

module rs_systematic_encoder #(
    parameter int MAX_PARITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [7:0]  data_byte,
    input  logic        last_data,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  parity_byte,
    output logic        last_parity,
    output logic        length_error,
    output logic        out_valid,
    input  logic        out_ready
);

    localparam int NW = $clog2(MAX_PARITY + 1);

    logic [rse_pkg::PC_W-1:0]   pc_reg;
    logic                       cfg_hit;
    logic [7:0]                 pc8;
    logic [NW-1:0]              n;
    logic                       gen_busy;
    logic [MAX_PARITY:0][7:0]   coeffs;

    logic [MAX_PARITY-1:0][7:0] rem_reg;
    logic [MAX_PARITY:0][7:0]   rem_ext;
    logic [MAX_PARITY-1:0][7:0] rem_upd;
    rse_pkg::gf_t               fb;
    logic [rse_pkg::CNT_W-1:0]  cnt_reg;
    logic [rse_pkg::CNT_W-1:0]  cnt_inc;
    logic [rse_pkg::SUM_W-1:0]  len_sum;
    logic                       len_err;

    logic [MAX_PARITY-1:0][7:0] pbuf_reg;
    logic [NW-1:0]              left_reg;
    logic                       err_reg;
    logic                       in_acc;
    logic                       out_acc;
    logic                       load;

    // config port
    assign pready  = 1'b1;
    assign cfg_hit = psel && penable && pwrite && pready
                     && (paddr[2] == rse_pkg::REG_PARITY_COUNT);
    assign prdata  = (paddr[2] == rse_pkg::REG_PARITY_COUNT)
                     ? {26'd0, pc_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rse_pkg::PC_RESET;
        end
        else if (cfg_hit)
        begin
            pc_reg <= pwdata[rse_pkg::PC_W-1:0];
        end
    end

    always_comb
    begin
        pc8 = {2'b00, pc_reg};
        priority if (pc8 == 8'd0)
        begin
            n = NW'(1);
        end
        else if (pc8 > 8'(MAX_PARITY))
        begin
            n = NW'(MAX_PARITY);
        end
        else
        begin
            n = NW'(pc8);
        end
    end

    rse_gen #(
        .MAX_PARITY (MAX_PARITY)
    ) u_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_hit),
        .n      (n),
        .busy   (gen_busy),
        .coeffs (coeffs)
    );

    // LFSR update; entries at or above n stay zero, as do coefficients above n
    always_comb
    begin
        rem_ext                   = '0;
        rem_ext[MAX_PARITY-1:0]   = rem_reg;
        fb = data_byte ^ rem_reg[0];
        for (int j = 0; j < MAX_PARITY; j++)
        begin
            rem_upd[j] = rem_ext[j+1] ^ rse_pkg::gf_mul(coeffs[j+1], fb);
        end
    end

    assign cnt_inc = (cnt_reg == rse_pkg::CNT_MAX) ? cnt_reg
                                                  : cnt_reg + rse_pkg::CNT_W'(1);
    assign len_sum = rse_pkg::SUM_W'(cnt_inc) + rse_pkg::SUM_W'(n);
    assign len_err = (len_sum >= rse_pkg::FIELD_SIZE);

    assign in_ready = !gen_busy && (!last_data || (left_reg == '0));
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign load     = in_acc && last_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cfg_hit || load)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (in_acc)
        begin
            rem_reg <= rem_upd;
            cnt_reg <= cnt_inc;
        end
    end

    // output shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (load)
        begin
            left_reg <= len_err ? NW'(1) : n;
            err_reg  <= len_err;
        end
        else if (out_acc)
        begin
            left_reg <= left_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pbuf_reg <= len_err ? '0 : rem_upd;
        end
        else if (out_acc)
        begin
            pbuf_reg <= pbuf_reg >> 8;
        end
    end

    assign out_valid    = (left_reg != '0);
    assign parity_byte  = pbuf_reg[0];
    assign last_parity  = (left_reg == NW'(1));
    assign length_error = err_reg;

    `ASSERT_IMPLY(a_no_accept_building, clk, rst_n, gen_busy, !in_ready,
                  "item accepted while generator builds")
    `ASSERT_NEXT(a_last_loads, clk, rst_n, in_acc && last_data, out_valid,
                 "no result after last data item")
    `ASSERT_NEXT(a_burst_ends, clk, rst_n, out_acc && last_parity, !out_valid,
                 "result shown after final parity item")
    `ASSERT_IMPLY(a_err_single, clk, rst_n, out_valid && length_error, last_parity,
                  "length error result not marked last")

endmodule

// ----- rtl/rse_gen.sv -----
// Generator polynomial builder: one (x + alpha^i) factor per cycle.
module rse_gen #(
    parameter int MAX_PARITY = 32,
    localparam int NW = $clog2(MAX_PARITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [NW-1:0]                     n,
    output logic                              busy,
    output logic [MAX_PARITY:0][7:0]          coeffs
);

    logic [MAX_PARITY:0][7:0] coeffs_reg;
    logic [MAX_PARITY:0][7:0] coeffs_next;
    rse_pkg::gf_t             root_reg;
    logic [NW-1:0]            step_reg;
    logic                     busy_reg;

    always_comb
    begin
        coeffs_next[0] = coeffs_reg[0];
        for (int k = 1; k <= MAX_PARITY; k++)
        begin
            coeffs_next[k] = coeffs_reg[k] ^ rse_pkg::gf_mul(coeffs_reg[k-1], root_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg    <= {{MAX_PARITY{8'h00}}, 8'h01};
            root_reg      <= 8'd1;
            step_reg      <= '0;
            busy_reg      <= 1'b1;
        end
        else if (start)
        begin
            coeffs_reg    <= {{MAX_PARITY{8'h00}}, 8'h01};
            root_reg      <= 8'd1;
            step_reg      <= '0;
            busy_reg      <= 1'b1;
        end
        else if (busy_reg)
        begin
            coeffs_reg <= coeffs_next;
            root_reg   <= rse_pkg::gf_xtime(root_reg);
            step_reg   <= step_reg + NW'(1);
            if (step_reg == n - NW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy   = busy_reg;
    assign coeffs = coeffs_reg;

endmodule
